// File: design/fph_pkg.sv
// ----------------------------------------------------------------------------
// fph_pkg
// Types and constants for packing two single-precision values as halves.
// ----------------------------------------------------------------------------
package fph_pkg;

    typedef logic [31:0] t_single;
    typedef logic [15:0] t_half;
    typedef logic [31:0] t_packed;

    // Biased single exponent codes and limits
    localparam logic [7:0]  EXP_ALL_ONES_F = 8'hFF;
    localparam logic [7:0]  EXP_INF_MIN    = 8'd143;  // half exponent 31 and above
    localparam logic [7:0]  EXP_NORM_MIN   = 8'd113;  // half exponent 1
    localparam logic [7:0]  EXP_SUB_MIN    = 8'd102;  // half exponent -10
    localparam logic [7:0]  EXP_REBIAS     = 8'd112;  // 127 - 15
    localparam logic [7:0]  SUB_SHIFT_BASE = 8'd126;  // shift = 126 - exponent

    // Half magnitude codes (sign excluded)
    localparam logic [14:0] HALF_INF_MAG   = 15'h7C00;
    localparam logic [14:0] HALF_QNAN_MAG  = 15'h7E00;
    localparam logic [14:0] HALF_ZERO_MAG  = 15'h0000;

endpackage

// File: design/fph_if.sv
// ----------------------------------------------------------------------------
// fph_if
// Valid/ready channels: float pair input and packed half output.
// ----------------------------------------------------------------------------
interface fph_in_if;
    logic             valid;
    logic             ready;
    fph_pkg::t_single low_float;
    fph_pkg::t_single high_float;

    modport source (output valid, output low_float, output high_float, input ready);
    modport sink   (input valid, input low_float, input high_float, output ready);
endinterface

interface fph_out_if;
    logic             valid;
    logic             ready;
    fph_pkg::t_packed packed_halves;

    modport source (output valid, output packed_halves, input ready);
    modport sink   (input valid, input packed_halves, output ready);
endinterface

// File: design/float_pair_to_half_packer_top.sv
// ----------------------------------------------------------------------------
// float_pair_to_half_packer_top
// Converts two single-precision values to half precision and packs them.
// ----------------------------------------------------------------------------
// Usage:
//   i_pair carries one item: low_float and high_float, single-precision bit
//   patterns. o_packed returns one item per input: packed_halves holds the
//   half of low_float in bits 15:0 and the half of high_float in bits 31:16.
//   Rounding is half up; NaN gives a quiet NaN, overflow gives infinity, tiny
//   values give half subnormals or signed zero.
//   Two conversion lanes work in parallel in the input cycle; the packed
//   word is registered in the output register, or in the skid register
//   while the receiver stalls. Throughput is one item per cycle while the
//   receiver does not stall, bounded by the single output register stage.
//   When the receiver stalls, one more item is taken into a skid register;
//   i_pair.ready then drops until the receiver takes the item in the output
//   register. No item is lost.
//   Reset (i_rst_n low, synchronous) empties the output and skid registers;
//   the block holds no other state.
// ----------------------------------------------------------------------------
module float_pair_to_half_packer_top (
    input  logic      i_clk,
    input  logic      i_rst_n,
    fph_in_if.sink    i_pair,
    fph_out_if.source o_packed
);

    fph_pkg::t_half lo_half;
    fph_pkg::t_half hi_half;

    // Lanes: one per element of the pair
    fph_lane u_lane_lo (
        .i_single (i_pair.low_float),
        .o_half   (lo_half)
    );

    fph_lane u_lane_hi (
        .i_single (i_pair.high_float),
        .o_half   (hi_half)
    );

    // Merge and output buffering
    fph_merge u_merge (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_lo_half (lo_half),
        .i_hi_half (hi_half),
        .i_pair    (i_pair),
        .o_packed  (o_packed)
    );

    // An item taken into an empty output shows up on the next cycle
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pair.valid && i_pair.ready && !o_packed.valid) |=> o_packed.valid)
        else $error("accepted item did not reach the output");

    // It carries the packed lane results
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pair.valid && i_pair.ready && !o_packed.valid)
            |=> (o_packed.packed_halves == $past({hi_half, lo_half})))
        else $error("packed word does not match lane results");

    // Back-pressure to the input only while the output holds an item
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_pair.ready |-> o_packed.valid)
        else $error("input stalled with an empty output");

endmodule

// File: design/fph_lane.sv
// ----------------------------------------------------------------------------
// fph_lane
// One conversion lane: single-precision bit pattern to half precision,
// round half up, subnormal and overflow handling.
// ----------------------------------------------------------------------------
module fph_lane (
    input  fph_pkg::t_single i_single,
    output fph_pkg::t_half   o_half
);

    logic        sgn;
    logic [7:0]  bexp;
    logic [22:0] frac;
    logic [23:0] man;
    logic [4:0]  hexp;
    logic [14:0] norm_mag;
    logic [4:0]  sub_sh;
    logic [4:0]  sub_sh_m1;
    logic [7:0]  sh_full;
    logic [7:0]  rebias;
    logic [23:0] sub_shifted;
    logic [23:0] sub_round_vec;
    logic [10:0] sub_mag;

    assign sgn  = i_single[31];
    assign bexp = i_single[30:23];
    assign frac = i_single[22:0];
    assign man  = {1'b1, frac};

    // Normal path: take top ten mantissa bits, add first dropped bit;
    // a carry ripples into the exponent and may reach infinity
    assign rebias   = bexp - fph_pkg::EXP_REBIAS;
    assign hexp     = rebias[4:0];
    assign norm_mag = {hexp, frac[22:13]} + {14'd0, frac[12]};

    // Subnormal path: shift in the hidden bit, shift range 14 to 24
    assign sh_full       = fph_pkg::SUB_SHIFT_BASE - bexp;
    assign sub_sh        = sh_full[4:0];
    assign sub_sh_m1     = sub_sh - 5'd1;
    assign sub_shifted   = man >> sub_sh;
    assign sub_round_vec = man >> sub_sh_m1;
    assign sub_mag       = sub_shifted[10:0] + {10'd0, sub_round_vec[0]};

    // Select by exponent range
    always_comb begin
        priority if (bexp == fph_pkg::EXP_ALL_ONES_F) begin
            o_half = {sgn, (frac != 23'd0) ? fph_pkg::HALF_QNAN_MAG : fph_pkg::HALF_INF_MAG};
        end else if (bexp >= fph_pkg::EXP_INF_MIN) begin
            o_half = {sgn, fph_pkg::HALF_INF_MAG};
        end else if (bexp >= fph_pkg::EXP_NORM_MIN) begin
            o_half = {sgn, norm_mag};
        end else if (bexp >= fph_pkg::EXP_SUB_MIN) begin
            o_half = {sgn, 4'd0, sub_mag};
        end else begin
            o_half = {sgn, fph_pkg::HALF_ZERO_MAG};
        end
    end

endmodule

// File: design/fph_merge.sv
// ----------------------------------------------------------------------------
// fph_merge
// Pack the two lane results into one word and hold it in an output
// register backed by a skid register, so input and output stall apart.
// ----------------------------------------------------------------------------
module fph_merge (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  fph_pkg::t_half i_lo_half,
    input  fph_pkg::t_half i_hi_half,
    fph_in_if.sink         i_pair,
    fph_out_if.source      o_packed
);

    logic             r_out_valid;
    logic             n_out_valid;
    fph_pkg::t_packed r_out_data;
    fph_pkg::t_packed n_out_data;
    logic             r_skid_valid;
    logic             n_skid_valid;
    fph_pkg::t_packed r_skid_data;
    fph_pkg::t_packed n_skid_data;
    fph_pkg::t_packed merged;
    logic             in_fire;
    logic             out_fire;

    assign merged   = {i_hi_half, i_lo_half};
    assign in_fire  = i_pair.valid && i_pair.ready;
    assign out_fire = r_out_valid && o_packed.ready;

    assign i_pair.ready           = !r_skid_valid;
    assign o_packed.valid         = r_out_valid;
    assign o_packed.packed_halves = r_out_data;

    // Advance output from skid first, else load the new item into the output
    // register or park it in skid while the receiver stalls, else empty on take
    always_comb begin
        n_out_valid  = r_out_valid;
        n_out_data   = r_out_data;
        n_skid_valid = r_skid_valid;
        n_skid_data  = r_skid_data;
        if (r_skid_valid) begin
            if (out_fire) begin
                n_out_data   = r_skid_data;
                n_skid_valid = 1'b0;
            end
        end else if (in_fire) begin
            if (!r_out_valid || out_fire) begin
                n_out_valid = 1'b1;
                n_out_data  = merged;
            end else begin
                n_skid_valid = 1'b1;
                n_skid_data  = merged;
            end
        end else if (out_fire) begin
            n_out_valid = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_out_data  <= n_out_data;
        r_skid_data <= n_skid_data;
    end

endmodule
